// File: hw/rtl/tfe_pkg.sv
// Shared types, constants and tables of the time format expander.
package tfe_pkg;

	localparam int LIMIT_MAX_DEF = 256;
	localparam int CHAR_W        = 8;
	localparam int BURST_LEN     = 9;
	localparam int BURST_N_W     = $clog2(BURST_LEN + 1);
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 9;

	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_WEEKDAY      = 3'd0,
		CFG_HOUR         = 3'd1,
		CFG_MINUTE       = 3'd2,
		CFG_YEAR_DAY     = 3'd3,
		CFG_OUTPUT_LIMIT = 3'd4
	} cfg_index_t;

	localparam logic [8:0] OUTPUT_LIMIT_RST = 9'd256;

	typedef struct packed {
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [8:0] year_day;
		logic [8:0] output_limit;
	} cfg_t;

	// One expansion handed from the expander to the burst emitter.
	typedef struct packed {
		logic                           valid;
		char_t [BURST_LEN-1:0]          chars;
		logic [BURST_N_W-1:0]           n;
		logic                           char_valid;
		logic                           end_of_text;
	} burst_load_t;

	localparam char_t CH_TERMINATOR = 8'h00;
	localparam char_t CH_PERCENT    = 8'h25;
	localparam char_t CH_ZERO       = 8'h30;
	localparam char_t SPEC_DAY_ABBR = 8'h61; // a
	localparam char_t SPEC_DAY_FULL = 8'h41; // A
	localparam char_t SPEC_HOUR     = 8'h48; // H
	localparam char_t SPEC_MINUTE   = 8'h4D; // M
	localparam char_t SPEC_WEEK_SUN = 8'h55; // U
	localparam char_t SPEC_WEEK_MON = 8'h57; // W
	localparam char_t SPEC_WEEKDAY  = 8'h77; // w

	localparam int DAYS_PER_WEEK = 7;
	localparam int ABBR_LEN      = 3;

	// Day names, left-justified, first character in the top byte.
	localparam logic [8*BURST_LEN-1:0] DAY_NAME [DAYS_PER_WEEK] = '{
		{"Sunday",    24'h0},
		{"Monday",    24'h0},
		{"Tuesday",   16'h0},
		{"Wednesday"},
		{"Thursday",  8'h0},
		{"Friday",    24'h0},
		{"Saturday",  8'h0}
	};

	localparam logic [BURST_N_W-1:0] DAY_LEN [DAYS_PER_WEEK] = '{
		4'd6, 4'd6, 4'd7, 4'd9, 4'd8, 4'd6, 4'd8
	};

endpackage

// File: hw/rtl/tfe_in_if.sv
// Format character channel.
interface tfe_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  format_char;

	modport source (output valid, output format_char, input ready);
	modport sink   (input valid, input format_char, output ready);
endinterface

// File: hw/rtl/tfe_out_if.sv
// Text character channel.
interface tfe_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_char;
	logic        char_valid;
	logic        end_of_text;
	logic        last_of_run;

	modport source (output valid, output out_char, output char_valid,
		output end_of_text, output last_of_run, input ready);
	modport sink   (input valid, input out_char, input char_valid,
		input end_of_text, input last_of_run, output ready);
endinterface

// File: hw/rtl/tfe_cfg_regs.sv
// Configuration register file of the time format expander.
module tfe_cfg_regs
	import tfe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weekday      <= '0;
			cfg_q.hour         <= '0;
			cfg_q.minute       <= '0;
			cfg_q.year_day     <= '0;
			cfg_q.output_limit <= OUTPUT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WEEKDAY:      cfg_q.weekday      <= cfg_data[2:0];
				CFG_HOUR:         cfg_q.hour         <= cfg_data[4:0];
				CFG_MINUTE:       cfg_q.minute       <= cfg_data[5:0];
				CFG_YEAR_DAY:     cfg_q.year_day     <= cfg_data[8:0];
				CFG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/tfe_expand.sv
// Input register, specifier state and expansion of one format character.
module tfe_expand
	import tfe_pkg::*;
#(
	parameter int LIMIT_MAX = LIMIT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tfe_in_if.sink      format,
	input  cfg_t        cfg,
	input  logic        load_ready,
	output burst_load_t load
);

	localparam int CNT_W = $clog2(LIMIT_MAX + 1);
	localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;

	logic             valid_s1;
	char_t            char_s1;
	logic             pending_q;
	logic [CNT_W-1:0] count_q;

	logic                 take;
	logic                 pending_d;
	logic [BURST_N_W-1:0] n_raw;
	logic [BURST_N_W-1:0] n_out;
	char_t [BURST_LEN-1:0] chars;
	logic                 is_term;
	logic                 term_char_valid;
	logic [LIM_W-1:0]     lim;
	logic [LIM_W-1:0]     room;
	logic [9:0]           week_num;
	logic [18:0]          week_prod;
	logic [6:0]           two_val;
	logic [3:0]           tens;
	logic [3:0]           ones;
	logic [2:0]           wd_mon;
	logic [2:0]           day_idx;

	// Tens digit of a value below one hundred.
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [3:0] t;
		t = '0;
		for (int k = 1; k < 10; k++) begin
			if (v >= 7'(k * 10))
				t = 4'(k);
		end
		return t;
	endfunction

	assign take         = valid_s1 && load_ready;
	assign format.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (format.valid && format.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (format.valid && format.ready)
			char_s1 <= format.format_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			count_q   <= '0;
		end else if (take) begin
			pending_q <= pending_d;
			count_q   <= is_term ? '0 : count_q + CNT_W'(n_out);
		end
	end

	always_comb begin
		lim = (LIM_W'(cfg.output_limit) > LIM_W'(LIMIT_MAX)) ?
			LIM_W'(LIMIT_MAX) : LIM_W'(cfg.output_limit);
		room = (lim > LIM_W'(count_q)) ? lim - LIM_W'(count_q) : '0;
	end

	// Week numbers share one reciprocal multiply: x * 293 >> 11 is x / 7 for x below 683.
	always_comb begin
		wd_mon = (cfg.weekday == 3'd0 || cfg.weekday == 3'd7) ? 3'd6 : cfg.weekday - 3'd1;
		if (char_s1 == SPEC_WEEK_MON)
			week_num = 10'(cfg.year_day) + 10'd7 - 10'(wd_mon);
		else
			week_num = 10'(cfg.year_day) + 10'd7 - 10'(cfg.weekday);
		week_prod = 19'(week_num) * 19'd293;
	end

	always_comb begin
		case (char_s1)
			SPEC_HOUR:   two_val = 7'(cfg.hour);
			SPEC_MINUTE: two_val = 7'(cfg.minute);
			default:     two_val = week_prod[17:11];
		endcase
		tens = tens_of(two_val);
		ones = 4'(two_val - 7'(tens) * 7'd10);
	end

	assign day_idx = (cfg.weekday == 3'd7) ? 3'd0 : cfg.weekday;

	always_comb begin
		chars           = '0;
		n_raw           = '0;
		pending_d       = 1'b0;
		is_term         = (char_s1 == CH_TERMINATOR);
		term_char_valid = pending_q && (room != '0);
		if (is_term) begin
			chars[0] = term_char_valid ? CH_PERCENT : CH_TERMINATOR;
			n_raw    = BURST_N_W'(1);
		end else if (!pending_q) begin
			if (char_s1 == CH_PERCENT) begin
				pending_d = 1'b1;
			end else begin
				chars[0] = char_s1;
				n_raw    = BURST_N_W'(1);
			end
		end else begin
			case (char_s1)
				SPEC_DAY_ABBR, SPEC_DAY_FULL: begin
					for (int i = 0; i < BURST_LEN; i++)
						chars[i] = DAY_NAME[day_idx][8*(BURST_LEN-i)-1 -: 8];
					if (cfg.weekday == 3'd7)
						n_raw = '0;
					else if (char_s1 == SPEC_DAY_ABBR)
						n_raw = BURST_N_W'(ABBR_LEN);
					else
						n_raw = DAY_LEN[day_idx];
				end
				SPEC_HOUR, SPEC_MINUTE, SPEC_WEEK_SUN, SPEC_WEEK_MON: begin
					chars[0] = CH_ZERO + char_t'(tens);
					chars[1] = CH_ZERO + char_t'(ones);
					n_raw    = BURST_N_W'(2);
				end
				SPEC_WEEKDAY: begin
					chars[0] = CH_ZERO + char_t'(cfg.weekday);
					n_raw    = BURST_N_W'(1);
				end
				default: begin
					chars[0] = CH_PERCENT;
					n_raw    = BURST_N_W'(1);
				end
			endcase
		end
		// The terminator always gives its one result, whatever room is left.
		if (!is_term && LIM_W'(n_raw) > room)
			n_out = room[BURST_N_W-1:0];
		else
			n_out = n_raw;
	end

	always_comb begin
		load.valid       = take && (n_out != '0);
		load.chars       = chars;
		load.n           = n_out;
		load.char_valid  = !is_term || term_char_valid;
		load.end_of_text = is_term;
	end

endmodule

// File: hw/rtl/tfe_burst.sv
// Burst buffer that streams the characters of one expansion to the output channel.
module tfe_burst
	import tfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  burst_load_t load,
	output logic        load_ready,
	tfe_out_if.source   text
);

	char_t                buf_q [BURST_LEN];
	logic                 busy_q;
	logic [BURST_N_W-1:0] idx_q;
	logic [BURST_N_W-1:0] last_idx_q;
	logic                 char_valid_q;
	logic                 eot_q;
	logic                 at_last;

	assign at_last    = (idx_q == last_idx_q);
	assign load_ready = !busy_q || (text.valid && text.ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load.valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (text.valid && text.ready) begin
			if (at_last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + BURST_N_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			for (int i = 0; i < BURST_LEN; i++)
				buf_q[i] <= load.chars[i];
			last_idx_q   <= load.n - BURST_N_W'(1);
			char_valid_q <= load.char_valid;
			eot_q        <= load.end_of_text;
		end
	end

	assign text.valid       = busy_q;
	assign text.out_char    = buf_q[idx_q];
	assign text.char_valid  = char_valid_q;
	assign text.end_of_text = eot_q;
	assign text.last_of_run = at_last;

endmodule

// File: hw/rtl/time_format_expander.sv
// Top level of the time format expander: streaming formatter for a subset of strftime.
//
// Format characters enter on the format channel, one per transaction; a zero character
// ends the string. Text leaves on the text channel, one character per transaction, with
// end_of_text on the single result of the terminator and last_of_run on the final result
// of each input character. The weekday, hour, minute, year day and output limit come
// from cfg_we/cfg_index/cfg_data; the user must change them only while idle (not enforced).
//
// An accepted character waits in the input register until the burst buffer takes its
// expansion, whose first character the burst buffer then offers on the text channel.
// Literal characters pass at one input per cycle while the receiver is ready; an
// expansion holds the burst buffer until all its characters are sent, one per cycle
// while the receiver is ready. Inputs with no result (an armed '%', text past the
// limit) pass only while the burst buffer is empty or is sending its last character.
//
// Reset clears the specifier state and the character count, empties both registers and
// loads the configuration defaults (output limit 256). When the receiver stalls, the burst
// buffer holds its character, one more input waits in the input register, and format.ready
// then falls until the buffer drains.
module time_format_expander
	import tfe_pkg::*;
#(
	parameter int LIMIT_MAX = LIMIT_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tfe_in_if.sink                 format,
	tfe_out_if.source              text,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t        cfg;
	burst_load_t load;
	logic        load_ready;

	tfe_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tfe_expand #(
		.LIMIT_MAX (LIMIT_MAX)
	) u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.format     (format),
		.cfg        (cfg),
		.load_ready (load_ready),
		.load       (load)
	);

	tfe_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_ready (load_ready),
		.text       (text)
	);

	// A new expansion only lands in an empty or draining burst buffer.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load.valid |-> load_ready)
		else $error("expansion loaded into a busy burst buffer");

	// A loaded expansion carries between one and BURST_LEN characters.
	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		load.valid |-> (load.n != '0 && load.n <= BURST_N_W'(BURST_LEN)))
		else $error("expansion length out of range");

	// The terminator result is always the only result of its input.
	a_eot_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.end_of_text) |-> text.last_of_run)
		else $error("end of text without last of run");

endmodule
